/* rtl/core/ecsm_pkg.sv */
// ecsm_pkg: shared types, constants and field helpers for the scalar multiply core
// no dependencies

package ecsm_pkg;

    localparam int DATA_W          = 32;
    localparam int SCALAR_W        = 31;
    localparam int SCALAR_BITS_DEF = 31;
    localparam int CNT_W           = $clog2(DATA_W);
    localparam logic [DATA_W-1:0] MODULUS_RST = 32'd7;

    // controller states
    typedef enum logic [4:0] {
        S_IDLE,
        S_RED_X,
        S_RED_Y,
        S_LOOP,
        S_NEXT,
        S_DBL,
        S_ADD_CHK,
        S_D_SQ,
        S_D_C3,
        S_D_C2,
        S_A_T0,
        S_A_D,
        S_POW_INIT,
        S_P_CHK,
        S_P_MUL,
        S_P_SQ,
        S_P_SH,
        S_LAM,
        S_LL,
        S_X3,
        S_Y_PREP,
        S_Y_MUL,
        S_Y_FIN,
        S_ADD_END,
        S_DONE
    } state_t;

    // datapath commands
    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_MUL_RX,
        OP_MUL_RY,
        OP_SHIFT_N,
        OP_SET_ADD,
        OP_SET_DBL,
        OP_R_S,
        OP_R_T,
        OP_R_INF,
        OP_MUL_SXSX,
        OP_MUL_C3,
        OP_MUL_C2,
        OP_SUB_T0,
        OP_SUB_D,
        OP_POW_INIT,
        OP_MUL_PW,
        OP_MUL_PB,
        OP_POW_SHIFT,
        OP_MUL_LAM,
        OP_MUL_LL,
        OP_X3_DBL,
        OP_X3_ADD,
        OP_Y_PREP,
        OP_MUL_Y,
        OP_Y_FIN,
        OP_WB_ACC,
        OP_WB_BASE
    } dp_op_t;

    typedef struct packed {
        logic p_zero;
        logic n_zero;
        logic n_lsb;
        logic n_next_zero;
        logic s_inf;
        logic t_inf;
        logic x_eq;
        logic add_inf;
        logic e_zero;
        logic e_lsb;
        logic mul_done;
    } dp_status_t;

    function automatic logic [DATA_W-1:0] fadd(input logic [DATA_W-1:0] a,
                                               input logic [DATA_W-1:0] b,
                                               input logic [DATA_W-1:0] p);
        logic [DATA_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, p})
            s = s - {1'b0, p};
        return s[DATA_W-1:0];
    endfunction

    function automatic logic [DATA_W-1:0] fsub(input logic [DATA_W-1:0] a,
                                               input logic [DATA_W-1:0] b,
                                               input logic [DATA_W-1:0] p);
        logic [DATA_W:0] s;
        if (a >= b)
            s = {1'b0, a} - {1'b0, b};
        else
            s = {1'b0, a} + {1'b0, p} - {1'b0, b};
        return s[DATA_W-1:0];
    endfunction

endpackage

/* rtl/core/ecsm_modmul.sv */
// ecsm_modmul: bit-serial modular multiplier, one bit of b per cycle, msb first
// depends on ecsm_pkg; requires a < p, b may be any value

module ecsm_modmul (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [ecsm_pkg::DATA_W-1:0]  a,
    input  logic [ecsm_pkg::DATA_W-1:0]  b,
    input  logic [ecsm_pkg::DATA_W-1:0]  p,
    output logic                         busy,
    output logic                         done,
    output logic [ecsm_pkg::DATA_W-1:0]  result
);

    localparam int W = ecsm_pkg::DATA_W;

    logic                        busy_reg, busy_next;
    logic [ecsm_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic [W-1:0]                acc_reg, acc_next;
    logic [W-1:0]                a_reg, a_next;
    logic [W-1:0]                b_reg, b_next;
    logic [W:0]                  dbl, dbl_red, sum;
    logic [W-1:0]                step;

    // acc = 2*acc + bit*a, reduced with two conditional subtracts
    always_comb
    begin
        dbl     = {acc_reg, 1'b0};
        dbl_red = (dbl >= {1'b0, p}) ? dbl - {1'b0, p} : dbl;
        sum     = dbl_red + (b_reg[W-1] ? {1'b0, a_reg} : '0);
        step    = (sum >= {1'b0, p}) ? sum[W-1:0] - p : sum[W-1:0];
    end

    assign done   = busy_reg && (cnt_reg == ecsm_pkg::CNT_W'(W - 1));
    assign busy   = busy_reg;
    assign result = step;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        if (busy_reg)
        begin
            acc_next = step;
            b_next   = {b_reg[W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (done)
                busy_next = 1'b0;
        end
        else if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            acc_next  = '0;
            a_next    = a;
            b_next    = b;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
    end

endmodule

/* rtl/core/ecsm_datapath.sv */
// ecsm_datapath: point and field registers, add/sub logic and the shared multiplier
// depends on ecsm_pkg and ecsm_modmul

module ecsm_datapath #(
    parameter int SCALAR_BITS = ecsm_pkg::SCALAR_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  ecsm_pkg::dp_op_t               op,
    input  logic [ecsm_pkg::DATA_W-1:0]    p,
    input  logic [ecsm_pkg::DATA_W-1:0]    point_x,
    input  logic [ecsm_pkg::DATA_W-1:0]    point_y,
    input  logic                           point_at_infinity,
    input  logic [ecsm_pkg::SCALAR_W-1:0]  scalar,
    output ecsm_pkg::dp_status_t           status,
    output logic [ecsm_pkg::DATA_W-1:0]    result_x,
    output logic [ecsm_pkg::DATA_W-1:0]    result_y,
    output logic                           result_infinity
);

    localparam int W = ecsm_pkg::DATA_W;

    logic [W-1:0] bx_reg, bx_next, by_reg, by_next;
    logic         binf_reg, binf_next;
    logic [W-1:0] ax_reg, ax_next, ay_reg, ay_next;
    logic         ainf_reg, ainf_next;
    logic [W-1:0] sx_reg, sx_next, sy_reg, sy_next;
    logic         sinf_reg, sinf_next;
    logic [W-1:0] tx_reg, tx_next, ty_reg, ty_next;
    logic         tinf_reg, tinf_next;
    logic [W-1:0] rx_reg, rx_next, ry_reg, ry_next;
    logic         rinf_reg, rinf_next;
    logic [W-1:0] t0_reg, t0_next, t1_reg, t1_next, d_reg, d_next;
    logic [W-1:0] pw_reg, pw_next, pb_reg, pb_next, e_reg, e_next;
    logic [W-1:0] lam_reg, lam_next, x3_reg, x3_next;
    logic [SCALAR_BITS-1:0] n_reg, n_next;

    logic [63:0]  scalar_ext;
    logic [W-1:0] one_p, two_p, three_p;
    logic         mul_start, mul_busy, mul_done;
    logic [W-1:0] mul_a, mul_b, mul_res;

    // small constants reduced mod p
    assign one_p   = (p == W'(1)) ? '0 : W'(1);
    assign two_p   = (p <= W'(2)) ? '0 : W'(2);
    assign three_p = (p == W'(1) || p == W'(3)) ? '0 : ((p == W'(2)) ? W'(1) : W'(3));

    assign scalar_ext = {{(64 - ecsm_pkg::SCALAR_W){1'b0}}, scalar};

    always_comb
    begin
        mul_start = !mul_busy;
        mul_a     = '0;
        mul_b     = '0;
        unique case (op)
            ecsm_pkg::OP_MUL_RX:   begin mul_a = one_p;   mul_b = bx_reg;  end
            ecsm_pkg::OP_MUL_RY:   begin mul_a = one_p;   mul_b = by_reg;  end
            ecsm_pkg::OP_MUL_SXSX: begin mul_a = sx_reg;  mul_b = sx_reg;  end
            ecsm_pkg::OP_MUL_C3:   begin mul_a = three_p; mul_b = t0_reg;  end
            ecsm_pkg::OP_MUL_C2:   begin mul_a = two_p;   mul_b = sy_reg;  end
            ecsm_pkg::OP_MUL_PW:   begin mul_a = pw_reg;  mul_b = pb_reg;  end
            ecsm_pkg::OP_MUL_PB:   begin mul_a = pb_reg;  mul_b = pb_reg;  end
            ecsm_pkg::OP_MUL_LAM:  begin mul_a = t0_reg;  mul_b = pw_reg;  end
            ecsm_pkg::OP_MUL_LL:   begin mul_a = lam_reg; mul_b = lam_reg; end
            ecsm_pkg::OP_MUL_Y:    begin mul_a = lam_reg; mul_b = t1_reg;  end
            default:               mul_start = 1'b0;
        endcase
    end

    ecsm_modmul u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mul_start),
        .a      (mul_a),
        .b      (mul_b),
        .p      (p),
        .busy   (mul_busy),
        .done   (mul_done),
        .result (mul_res)
    );

    always_comb
    begin
        bx_next = bx_reg;  by_next = by_reg;  binf_next = binf_reg;
        ax_next = ax_reg;  ay_next = ay_reg;  ainf_next = ainf_reg;
        sx_next = sx_reg;  sy_next = sy_reg;  sinf_next = sinf_reg;
        tx_next = tx_reg;  ty_next = ty_reg;  tinf_next = tinf_reg;
        rx_next = rx_reg;  ry_next = ry_reg;  rinf_next = rinf_reg;
        t0_next = t0_reg;  t1_next = t1_reg;  d_next = d_reg;
        pw_next = pw_reg;  pb_next = pb_reg;  e_next = e_reg;
        lam_next = lam_reg; x3_next = x3_reg; n_next = n_reg;
        unique case (op)
            ecsm_pkg::OP_LOAD:
            begin
                bx_next   = point_x;
                by_next   = point_y;
                binf_next = point_at_infinity;
                ax_next   = '0;
                ay_next   = '0;
                ainf_next = 1'b1;
                n_next    = scalar_ext[SCALAR_BITS-1:0];
            end
            ecsm_pkg::OP_MUL_RX:   if (mul_done) bx_next = mul_res;
            ecsm_pkg::OP_MUL_RY:   if (mul_done) by_next = mul_res;
            ecsm_pkg::OP_SHIFT_N:  n_next = n_reg >> 1;
            ecsm_pkg::OP_SET_ADD:
            begin
                sx_next = ax_reg; sy_next = ay_reg; sinf_next = ainf_reg;
                tx_next = bx_reg; ty_next = by_reg; tinf_next = binf_reg;
            end
            ecsm_pkg::OP_SET_DBL:
            begin
                sx_next = bx_reg; sy_next = by_reg; sinf_next = binf_reg;
                tx_next = bx_reg; ty_next = by_reg; tinf_next = binf_reg;
            end
            ecsm_pkg::OP_R_S:
            begin
                rx_next = sx_reg; ry_next = sy_reg; rinf_next = sinf_reg;
            end
            ecsm_pkg::OP_R_T:
            begin
                rx_next = tx_reg; ry_next = ty_reg; rinf_next = tinf_reg;
            end
            ecsm_pkg::OP_R_INF:
            begin
                rx_next = '0; ry_next = '0; rinf_next = 1'b1;
            end
            ecsm_pkg::OP_MUL_SXSX: if (mul_done) t0_next = mul_res;
            ecsm_pkg::OP_MUL_C3:   if (mul_done) t0_next = mul_res;
            ecsm_pkg::OP_MUL_C2:   if (mul_done) d_next = mul_res;
            ecsm_pkg::OP_SUB_T0:   t0_next = ecsm_pkg::fsub(ty_reg, sy_reg, p);
            ecsm_pkg::OP_SUB_D:    d_next = ecsm_pkg::fsub(tx_reg, sx_reg, p);
            ecsm_pkg::OP_POW_INIT:
            begin
                pw_next = one_p;
                pb_next = d_reg;
                e_next  = p - W'(2);
            end
            ecsm_pkg::OP_MUL_PW:   if (mul_done) pw_next = mul_res;
            ecsm_pkg::OP_MUL_PB:   if (mul_done) pb_next = mul_res;
            ecsm_pkg::OP_POW_SHIFT: e_next = e_reg >> 1;
            ecsm_pkg::OP_MUL_LAM:  if (mul_done) lam_next = mul_res;
            ecsm_pkg::OP_MUL_LL:   if (mul_done) t1_next = mul_res;
            ecsm_pkg::OP_X3_DBL:
                x3_next = ecsm_pkg::fsub(t1_reg, ecsm_pkg::fadd(sx_reg, sx_reg, p), p);
            ecsm_pkg::OP_X3_ADD:
                x3_next = ecsm_pkg::fsub(ecsm_pkg::fsub(t1_reg, sx_reg, p), tx_reg, p);
            ecsm_pkg::OP_Y_PREP:   t1_next = ecsm_pkg::fsub(sx_reg, x3_reg, p);
            ecsm_pkg::OP_MUL_Y:    if (mul_done) t1_next = mul_res;
            ecsm_pkg::OP_Y_FIN:
            begin
                rx_next   = x3_reg;
                ry_next   = ecsm_pkg::fsub(t1_reg, sy_reg, p);
                rinf_next = 1'b0;
            end
            ecsm_pkg::OP_WB_ACC:
            begin
                ax_next = rx_reg; ay_next = ry_reg; ainf_next = rinf_reg;
            end
            ecsm_pkg::OP_WB_BASE:
            begin
                bx_next = rx_reg; by_next = ry_reg; binf_next = rinf_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        bx_reg <= bx_next;  by_reg <= by_next;  binf_reg <= binf_next;
        ax_reg <= ax_next;  ay_reg <= ay_next;  ainf_reg <= ainf_next;
        sx_reg <= sx_next;  sy_reg <= sy_next;  sinf_reg <= sinf_next;
        tx_reg <= tx_next;  ty_reg <= ty_next;  tinf_reg <= tinf_next;
        rx_reg <= rx_next;  ry_reg <= ry_next;  rinf_reg <= rinf_next;
        t0_reg <= t0_next;  t1_reg <= t1_next;  d_reg <= d_next;
        pw_reg <= pw_next;  pb_reg <= pb_next;  e_reg <= e_next;
        lam_reg <= lam_next; x3_reg <= x3_next; n_reg <= n_next;
    end

    always_comb
    begin
        status.p_zero      = (p == '0);
        status.n_zero      = (n_reg == '0);
        status.n_lsb       = n_reg[0];
        status.n_next_zero = ((n_reg >> 1) == '0);
        status.s_inf       = sinf_reg;
        status.t_inf       = tinf_reg;
        status.x_eq        = (sx_reg == tx_reg);
        status.add_inf     = (ecsm_pkg::fadd(sy_reg, ty_reg, p) == '0)
                             || (sy_reg != ty_reg) || (sy_reg == '0);
        status.e_zero      = (e_reg == '0);
        status.e_lsb       = e_reg[0];
        status.mul_done    = mul_done;
    end

    assign result_x        = ainf_reg ? '0 : ax_reg;
    assign result_y        = ainf_reg ? '0 : ay_reg;
    assign result_infinity = ainf_reg;

endmodule

/* rtl/core/ecsm_ctrl.sv */
// ecsm_ctrl: sequencer for double-and-add, point addition and fermat inversion
// depends on ecsm_pkg

module ecsm_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  ecsm_pkg::dp_status_t  status,
    output ecsm_pkg::dp_op_t      op,
    output logic                  busy,
    output logic                  done
);

    ecsm_pkg::state_t state_reg, state_next;
    logic             dbl_reg, dbl_next;
    logic             tang_reg, tang_next;

    // next state
    always_comb
    begin
        state_next = state_reg;
        dbl_next   = dbl_reg;
        tang_next  = tang_reg;
        unique case (state_reg)
            ecsm_pkg::S_IDLE:
                if (start)
                    state_next = status.p_zero ? ecsm_pkg::S_DONE : ecsm_pkg::S_RED_X;
            ecsm_pkg::S_RED_X:
                if (status.mul_done) state_next = ecsm_pkg::S_RED_Y;
            ecsm_pkg::S_RED_Y:
                if (status.mul_done) state_next = ecsm_pkg::S_LOOP;
            ecsm_pkg::S_LOOP:
            begin
                priority if (status.n_zero)
                    state_next = ecsm_pkg::S_DONE;
                else if (status.n_lsb)
                begin
                    state_next = ecsm_pkg::S_ADD_CHK;
                    dbl_next   = 1'b0;
                end
                else
                    state_next = ecsm_pkg::S_NEXT;
            end
            ecsm_pkg::S_NEXT:
                state_next = status.n_next_zero ? ecsm_pkg::S_DONE : ecsm_pkg::S_DBL;
            ecsm_pkg::S_DBL:
            begin
                state_next = ecsm_pkg::S_ADD_CHK;
                dbl_next   = 1'b1;
            end
            ecsm_pkg::S_ADD_CHK:
            begin
                priority if (status.s_inf || status.t_inf)
                    state_next = ecsm_pkg::S_ADD_END;
                else if (status.x_eq)
                begin
                    tang_next  = 1'b1;
                    state_next = status.add_inf ? ecsm_pkg::S_ADD_END : ecsm_pkg::S_D_SQ;
                end
                else
                begin
                    tang_next  = 1'b0;
                    state_next = ecsm_pkg::S_A_T0;
                end
            end
            ecsm_pkg::S_D_SQ:
                if (status.mul_done) state_next = ecsm_pkg::S_D_C3;
            ecsm_pkg::S_D_C3:
                if (status.mul_done) state_next = ecsm_pkg::S_D_C2;
            ecsm_pkg::S_D_C2:
                if (status.mul_done) state_next = ecsm_pkg::S_POW_INIT;
            ecsm_pkg::S_A_T0:     state_next = ecsm_pkg::S_A_D;
            ecsm_pkg::S_A_D:      state_next = ecsm_pkg::S_POW_INIT;
            ecsm_pkg::S_POW_INIT: state_next = ecsm_pkg::S_P_CHK;
            ecsm_pkg::S_P_CHK:
            begin
                priority if (status.e_zero)
                    state_next = ecsm_pkg::S_LAM;
                else if (status.e_lsb)
                    state_next = ecsm_pkg::S_P_MUL;
                else
                    state_next = ecsm_pkg::S_P_SQ;
            end
            ecsm_pkg::S_P_MUL:
                if (status.mul_done) state_next = ecsm_pkg::S_P_SQ;
            ecsm_pkg::S_P_SQ:
                if (status.mul_done) state_next = ecsm_pkg::S_P_SH;
            ecsm_pkg::S_P_SH:     state_next = ecsm_pkg::S_P_CHK;
            ecsm_pkg::S_LAM:
                if (status.mul_done) state_next = ecsm_pkg::S_LL;
            ecsm_pkg::S_LL:
                if (status.mul_done) state_next = ecsm_pkg::S_X3;
            ecsm_pkg::S_X3:       state_next = ecsm_pkg::S_Y_PREP;
            ecsm_pkg::S_Y_PREP:   state_next = ecsm_pkg::S_Y_MUL;
            ecsm_pkg::S_Y_MUL:
                if (status.mul_done) state_next = ecsm_pkg::S_Y_FIN;
            ecsm_pkg::S_Y_FIN:    state_next = ecsm_pkg::S_ADD_END;
            ecsm_pkg::S_ADD_END:
                state_next = dbl_reg ? ecsm_pkg::S_LOOP : ecsm_pkg::S_NEXT;
            ecsm_pkg::S_DONE:     state_next = ecsm_pkg::S_IDLE;
            default:              state_next = ecsm_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        op = ecsm_pkg::OP_NONE;
        unique case (state_reg)
            ecsm_pkg::S_IDLE:     if (start) op = ecsm_pkg::OP_LOAD;
            ecsm_pkg::S_RED_X:    op = ecsm_pkg::OP_MUL_RX;
            ecsm_pkg::S_RED_Y:    op = ecsm_pkg::OP_MUL_RY;
            ecsm_pkg::S_LOOP:
                if (!status.n_zero && status.n_lsb) op = ecsm_pkg::OP_SET_ADD;
            ecsm_pkg::S_NEXT:     op = ecsm_pkg::OP_SHIFT_N;
            ecsm_pkg::S_DBL:      op = ecsm_pkg::OP_SET_DBL;
            ecsm_pkg::S_ADD_CHK:
            begin
                priority if (status.s_inf)
                    op = ecsm_pkg::OP_R_T;
                else if (status.t_inf)
                    op = ecsm_pkg::OP_R_S;
                else if (status.x_eq && status.add_inf)
                    op = ecsm_pkg::OP_R_INF;
                else
                    op = ecsm_pkg::OP_NONE;
            end
            ecsm_pkg::S_D_SQ:     op = ecsm_pkg::OP_MUL_SXSX;
            ecsm_pkg::S_D_C3:     op = ecsm_pkg::OP_MUL_C3;
            ecsm_pkg::S_D_C2:     op = ecsm_pkg::OP_MUL_C2;
            ecsm_pkg::S_A_T0:     op = ecsm_pkg::OP_SUB_T0;
            ecsm_pkg::S_A_D:      op = ecsm_pkg::OP_SUB_D;
            ecsm_pkg::S_POW_INIT: op = ecsm_pkg::OP_POW_INIT;
            ecsm_pkg::S_P_CHK:    op = ecsm_pkg::OP_NONE;
            ecsm_pkg::S_P_MUL:    op = ecsm_pkg::OP_MUL_PW;
            ecsm_pkg::S_P_SQ:     op = ecsm_pkg::OP_MUL_PB;
            ecsm_pkg::S_P_SH:     op = ecsm_pkg::OP_POW_SHIFT;
            ecsm_pkg::S_LAM:      op = ecsm_pkg::OP_MUL_LAM;
            ecsm_pkg::S_LL:       op = ecsm_pkg::OP_MUL_LL;
            ecsm_pkg::S_X3:       op = tang_reg ? ecsm_pkg::OP_X3_DBL : ecsm_pkg::OP_X3_ADD;
            ecsm_pkg::S_Y_PREP:   op = ecsm_pkg::OP_Y_PREP;
            ecsm_pkg::S_Y_MUL:    op = ecsm_pkg::OP_MUL_Y;
            ecsm_pkg::S_Y_FIN:    op = ecsm_pkg::OP_Y_FIN;
            ecsm_pkg::S_ADD_END:  op = dbl_reg ? ecsm_pkg::OP_WB_BASE : ecsm_pkg::OP_WB_ACC;
            ecsm_pkg::S_DONE:     op = ecsm_pkg::OP_NONE;
            default:              op = ecsm_pkg::OP_NONE;
        endcase
    end

    assign busy = (state_reg != ecsm_pkg::S_IDLE);
    assign done = (state_reg == ecsm_pkg::S_DONE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ecsm_pkg::S_IDLE;
            dbl_reg   <= 1'b0;
            tang_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            dbl_reg   <= dbl_next;
            tang_reg  <= tang_next;
        end
    end

endmodule

/* rtl/core/ec_point_scalar_multiply_mod_p.sv */
// ec_point_scalar_multiply_mod_p: affine scalar multiply on y^2 = x^3 + b mod p
// depends on ecsm_pkg, ecsm_ctrl, ecsm_datapath (which holds ecsm_modmul)
//
// channel  | direction | handshake              | payload
// ---------+-----------+------------------------+----------------------------------------
// item in  | in        | start, taken when !busy| point_x, point_y, point_at_infinity,
//          |           |                        | scalar
// result   | out       | done, one-cycle strobe | result_x, result_y, result_infinity
// config   | in        | cfg_we                 | cfg_data -> modulus register
//
// one item at a time; every field multiply loads its operands, then runs 32 one-bit steps
// each point operation is dominated by the fermat inversion: up to 64 multiplies
// plus 6 more and the add/sub and register steps between them; an item needs
// up to 2*SCALAR_BITS-1 point operations; reset clears the controller and sets the modulus
// to 7; results are not held back: done and the result ports are valid for one cycle and
// must be taken then

module ec_point_scalar_multiply_mod_p #(
    parameter int SCALAR_BITS = ecsm_pkg::SCALAR_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [ecsm_pkg::DATA_W-1:0]    point_x,
    input  logic [ecsm_pkg::DATA_W-1:0]    point_y,
    input  logic                           point_at_infinity,
    input  logic [ecsm_pkg::SCALAR_W-1:0]  scalar,
    output logic                           done,
    output logic [ecsm_pkg::DATA_W-1:0]    result_x,
    output logic [ecsm_pkg::DATA_W-1:0]    result_y,
    output logic                           result_infinity,
    input  logic                           cfg_we,
    input  logic [ecsm_pkg::DATA_W-1:0]    cfg_data
);

    // field modulus, to be written only while the core is idle; the block does not enforce this
    logic [ecsm_pkg::DATA_W-1:0] modulus_reg, modulus_next;

    ecsm_pkg::dp_op_t     op;
    ecsm_pkg::dp_status_t status;

    assign modulus_next = cfg_we ? cfg_data : modulus_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            modulus_reg <= ecsm_pkg::MODULUS_RST;
        else
            modulus_reg <= modulus_next;
    end

    // sequencer: double-and-add over the scalar, with point add and inversion steps
    ecsm_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .op     (op),
        .busy   (busy),
        .done   (done)
    );

    // register file of points and temporaries plus the shared multiplier;
    // the result ports follow the accumulator, which is stable while done is high
    ecsm_datapath #(
        .SCALAR_BITS (SCALAR_BITS)
    ) u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .op                (op),
        .p                 (modulus_reg),
        .point_x           (point_x),
        .point_y           (point_y),
        .point_at_infinity (point_at_infinity),
        .scalar            (scalar),
        .status            (status),
        .result_x          (result_x),
        .result_y          (result_y),
        .result_infinity   (result_infinity)
    );

endmodule

/* bench/tb_ec_point_scalar_multiply_mod_p.sv */
// tb_ec_point_scalar_multiply_mod_p: self-checking bench for the affine scalar multiply core
// depends on ecsm_pkg and ec_point_scalar_multiply_mod_p; a built-in double-and-add
// predictor works out each product, a monitor compares every done strobe with it
`timescale 1ns / 100ps

module tb_ec_point_scalar_multiply_mod_p;

    localparam int DATA_W         = ecsm_pkg::DATA_W;
    localparam int SCALAR_W       = ecsm_pkg::SCALAR_W;
    localparam int WATCHDOG_LIMIT = 1000000;
    localparam int DRAIN_CYCLES   = 20;

    // one product point as the block reports it
    typedef struct {
        logic [DATA_W-1:0] x;
        logic [DATA_W-1:0] y;
        logic              inf;
    } ec_point_t;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic [DATA_W-1:0]   point_x;
    logic [DATA_W-1:0]   point_y;
    logic                point_at_infinity;
    logic [SCALAR_W-1:0] scalar;
    logic                done;
    logic [DATA_W-1:0]   result_x;
    logic [DATA_W-1:0]   result_y;
    logic                result_infinity;
    logic                cfg_we;
    logic [DATA_W-1:0]   cfg_data;

    // predictor copy of the modulus register
    logic [DATA_W-1:0] field_p;
    // products still owed by the block, oldest first
    ec_point_t         pending_products[$];
    int                error_count;
    int                idle_cycles;
    logic              item_taken;

    ec_point_scalar_multiply_mod_p uut (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (start),
        .busy              (busy),
        .point_x           (point_x),
        .point_y           (point_y),
        .point_at_infinity (point_at_infinity),
        .scalar            (scalar),
        .done              (done),
        .result_x          (result_x),
        .result_y          (result_y),
        .result_infinity   (result_infinity),
        .cfg_we            (cfg_we),
        .cfg_data          (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ---------------- field arithmetic of the predictor ----------------

    function automatic logic [DATA_W-1:0] mod_mul(logic [DATA_W-1:0] a, logic [DATA_W-1:0] b,
                                                  logic [DATA_W-1:0] p);
        logic [63:0] prod;
        prod = {32'd0, a} * {32'd0, b};
        return DATA_W'(prod % {32'd0, p});
    endfunction

    function automatic logic [DATA_W-1:0] mod_sum(logic [DATA_W-1:0] a, logic [DATA_W-1:0] b,
                                                  logic [DATA_W-1:0] p);
        logic [DATA_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, p})
            s = s - {1'b0, p};
        return s[DATA_W-1:0];
    endfunction

    function automatic logic [DATA_W-1:0] mod_diff(logic [DATA_W-1:0] a, logic [DATA_W-1:0] b,
                                                   logic [DATA_W-1:0] p);
        logic [DATA_W:0] s;
        if (a >= b)
            s = {1'b0, a} - {1'b0, b};
        else
            s = {1'b0, a} + {1'b0, p} - {1'b0, b};
        return s[DATA_W-1:0];
    endfunction

    // square-and-multiply, exponent taken as is (p-2 wraps for p < 2)
    function automatic logic [DATA_W-1:0] mod_exp(logic [DATA_W-1:0] b, logic [DATA_W-1:0] e,
                                                  logic [DATA_W-1:0] p);
        logic [DATA_W-1:0] acc;
        acc = DATA_W'(1) % p;
        while (e != 0)
        begin
            if (e[0])
                acc = mod_mul(acc, b, p);
            b = mod_mul(b, b, p);
            e = e >> 1;
        end
        return acc;
    endfunction

    function automatic ec_point_t infinity_point();
        ec_point_t r;
        r.x = '0;
        r.y = '0;
        r.inf = 1'b1;
        return r;
    endfunction

    // affine chord/tangent sum with curve coefficient a = 0
    function automatic ec_point_t point_sum(ec_point_t s, ec_point_t t, logic [DATA_W-1:0] p);
        logic [DATA_W-1:0] slope;
        logic [DATA_W-1:0] x3;
        ec_point_t         r;
        if (s.inf)
            return t;
        if (t.inf)
            return s;
        if (s.x == t.x)
        begin
            // opposite points, mismatched y and vertical tangent all give infinity
            if (mod_sum(s.y, t.y, p) == 0 || s.y != t.y || s.y == 0)
                return infinity_point();
            slope = mod_mul(mod_mul(DATA_W'(3) % p, mod_mul(s.x, s.x, p), p),
                            mod_exp(mod_mul(DATA_W'(2) % p, s.y, p), p - 2, p), p);
            x3 = mod_diff(mod_mul(slope, slope, p), mod_sum(s.x, s.x, p), p);
        end
        else
        begin
            slope = mod_mul(mod_diff(t.y, s.y, p), mod_exp(mod_diff(t.x, s.x, p), p - 2, p), p);
            x3 = mod_diff(mod_diff(mod_mul(slope, slope, p), s.x, p), t.x, p);
        end
        r.x = x3;
        r.y = mod_diff(mod_mul(slope, mod_diff(s.x, x3, p), p), s.y, p);
        r.inf = 1'b0;
        return r;
    endfunction

    // right-to-left double-and-add over the low SCALAR_BITS_DEF bits
    function automatic ec_point_t scalar_product(logic [DATA_W-1:0] px, logic [DATA_W-1:0] py,
                                                 logic pinf, logic [SCALAR_W-1:0] k,
                                                 logic [DATA_W-1:0] p);
        ec_point_t base;
        ec_point_t acc;
        acc = infinity_point();
        if (p != 0)
        begin
            base.x = px % p;
            base.y = py % p;
            base.inf = pinf;
            while (k != 0)
            begin
                if (k[0])
                    acc = point_sum(acc, base, p);
                k = k >> 1;
                if (k != 0)
                    base = point_sum(base, base, p);
            end
        end
        if (acc.inf)
            acc = infinity_point();
        return acc;
    endfunction

    // ---------------- stimulus helpers ----------------

    // mostly short gaps, now and then a long one
    function automatic int random_gap();
        if ($urandom_range(9) < 8)
            return $urandom_range(2);
        return $urandom_range(40, 5);
    endfunction

    // present one item, hold it until the block takes it, then log the expected product
    task automatic send_item(logic [DATA_W-1:0] x, logic [DATA_W-1:0] y, logic inf,
                             logic [SCALAR_W-1:0] k);
        int gap;
        gap = random_gap();
        repeat (gap) @(negedge clk);
        point_x = x;
        point_y = y;
        point_at_infinity = inf;
        scalar = k;
        start = 1'b1;
        item_taken = 1'b0;
        while (!item_taken)
        begin
            @(posedge clk);
            if (!busy)
            begin
                item_taken = 1'b1;
                pending_products.insert(pending_products.size(),
                                        scalar_product(x, y, inf, k, field_p));
            end
        end
        @(negedge clk);
        start = 1'b0;
    endtask

    // sender holds off until every product is back and the core has settled
    task automatic wait_all_products();
        while (pending_products.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // modulus is only touched with the core idle
    task automatic set_modulus(logic [DATA_W-1:0] value);
        wait_all_products();
        cfg_data = value;
        cfg_we = 1'b1;
        @(negedge clk);
        cfg_we = 1'b0;
        field_p = value;
    endtask

    // ---------------- test tasks ----------------

    // reset value 7: zero scalar, unit scalar, infinity base, extremes of the fields
    task automatic test_reset_modulus();
        send_item(32'd3, 32'd1, 1'b0, '0);
        send_item(32'd3, 32'd1, 1'b0, 31'd1);
        send_item(32'd3, 32'd1, 1'b0, 31'd2);
        send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 31'd5);
        send_item(32'd0, 32'd0, 1'b1, 31'h7FFF_FFFF);
        // x = 0 points have order 3, so 3P meets the opposite point
        send_item(32'd0, 32'd3, 1'b0, 31'd3);
        send_item(32'd0, 32'd3, 1'b0, 31'd6);
        // y = 0 doubling collapses to infinity
        send_item(32'd4, 32'd0, 1'b0, 31'h4000_0000);
        send_item(32'd4, 32'd7, 1'b0, 31'd3);
        // same x with unrelated y values, off the curve
        send_item(32'd2, 32'd5, 1'b0, 31'd7);
        wait_all_products();
    endtask

    // a small prime and the largest 32-bit prime modulus, plus one full-length scalar
    task automatic test_modulus_extremes();
        set_modulus(32'd5);
        send_item(32'd1, 32'd2, 1'b0, 31'd9);
        send_item(32'hFFFF_FFFE, 32'd3, 1'b0, 31'd4);
        set_modulus(32'd4294967291);
        send_item(32'hFFFF_FFFF, 32'hFFFF_FFFA, 1'b0, 31'd3);
        send_item(32'h1234_5678, 32'h9ABC_DEF0, 1'b0, 31'h7FFF_FFFF);
        send_item(32'd0, 32'd0, 1'b0, 31'd2);
        wait_all_products();
    endtask

    // degenerate moduli: zero gives infinity at once, 1 wraps the exponent, 2 makes it zero
    task automatic test_degenerate_modulus();
        set_modulus(32'd0);
        repeat (6)
            send_item($urandom, $urandom, 1'($urandom), 31'($urandom));
        set_modulus(32'd1);
        send_item(32'd5, 32'd6, 1'b0, 31'd3);
        set_modulus(32'd2);
        send_item(32'd1, 32'd1, 1'b0, 31'd3);
        send_item(32'd1, 32'd0, 1'b0, 31'd2);
        wait_all_products();
    endtask

    // random points under a range of moduli, mostly short scalars to bound run time
    task automatic test_random_points();
        logic [DATA_W-1:0] moduli[7] = '{32'd7, 32'd251, 32'd65521, 32'd1000003,
                                         32'd2147483647, 32'd4294967291, 32'd97};
        logic [DATA_W-1:0] x;
        logic [DATA_W-1:0] y;
        logic [SCALAR_W-1:0] k;
        logic inf;
        int pick;
        for (int phase = 0; phase < 8; phase++)
        begin
            // one phase runs with an arbitrary odd modulus, not necessarily prime
            if (phase == 7)
                set_modulus($urandom | 32'd1);
            else
                set_modulus(moduli[phase]);
            for (int i = 0; i < 11; i++)
            begin
                x = $urandom;
                y = $urandom;
                inf = 1'b0;
                pick = $urandom_range(19);
                if (pick < 15)
                    k = 31'($urandom_range(15));
                else if (pick < 17)
                    k = 31'($urandom_range(255, 16));
                else if (pick < 18)
                begin
                    // infinity base: full scalar is cheap
                    inf = 1'b1;
                    k = 31'($urandom);
                end
                else
                begin
                    // base with y = 0 doubles into infinity, so the high bits are cheap
                    y = 32'd0;
                    k = 31'($urandom);
                end
                // small field: reuse a handful of x values so equal-x cases occur
                if (phase == 0 && pick < 8)
                    x = $urandom_range(6);
                send_item(x, y, inf, k);
            end
        end
        wait_all_products();
    endtask

    // ---------------- result check ----------------

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_products.size() == 0)
            begin
                $error("unexpected result x=%h y=%h inf=%b", result_x, result_y,
                       result_infinity);
                error_count++;
            end
            else
            begin
                ec_point_t want;
                want = pending_products.pop_front();
                if (result_x !== want.x)
                begin
                    $error("result_x expected %h actual %h", want.x, result_x);
                    error_count++;
                end
                if (result_y !== want.y)
                begin
                    $error("result_y expected %h actual %h", want.y, result_y);
                    error_count++;
                end
                if (result_infinity !== want.inf)
                begin
                    $error("result_infinity expected %b actual %b", want.inf,
                           result_infinity);
                    error_count++;
                end
            end
        end
    end

    // watchdog: cycles with neither an item taken nor a result delivered
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // ---------------- sequence ----------------

    initial
    begin
        error_count = 0;
        idle_cycles = 0;
        item_taken = 1'b0;
        field_p = ecsm_pkg::MODULUS_RST;
        rst_n = 1'b0;
        start = 1'b0;
        point_x = '0;
        point_y = '0;
        point_at_infinity = 1'b0;
        scalar = '0;
        cfg_we = 1'b0;
        cfg_data = '0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_reset_modulus();
        test_modulus_extremes();
        test_degenerate_modulus();
        test_random_points();

        wait_all_products();
        if (error_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
